// File: design/delimited_frame_length_checker_assert.svh
// assertion macros shared by the frame length checker's checker file
`ifndef DELIMITED_FRAME_LENGTH_CHECKER_ASSERT_SVH
`define DELIMITED_FRAME_LENGTH_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DFLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DFLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dflc_pkg.sv
// shared widths, status codes and interface structs of the frame length checker
package dflc_pkg;

    localparam int BODY_W = 17;
    localparam int DECL_W = 18;
    localparam int MAG_W  = 17;

    localparam logic [BODY_W-1:0] BODY_MAX = {BODY_W{1'b1}};
    localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_MISMATCH = 2'd1;
    localparam status_t STATUS_MISSING  = 2'd2;

    typedef struct packed {
        logic              frame_end;
        logic [BODY_W-1:0] body_length;
    } frame_info_t;

    typedef struct packed {
        logic             digits_seen;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } field_info_t;

endpackage

// File: design/dflc_delim_track.sv
// delimiter matcher and saturating body byte counter
module dflc_delim_track
    import dflc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    output frame_info_t info
);

    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [7:0] DELIM_PAT [4] = '{CR, LF, CR, LF};
    localparam logic [1:0] DELIM_LAST = 2'd3;
    localparam logic [BODY_W-1:0] DELIM_PRE = BODY_W'(3);

    logic [1:0]        prog_reg;
    logic [1:0]        prog_next;
    logic [BODY_W-1:0] count_reg;
    logic [BODY_W-1:0] count_next;
    logic              match;
    logic              frame_end;

    assign match     = (data_byte == DELIM_PAT[prog_reg]);
    assign frame_end = match && (prog_reg == DELIM_LAST);

    always_comb
    begin
        if (frame_end)
        begin
            prog_next  = 2'd0;
            count_next = '0;
        end
        else
        begin
            if (match)
            begin
                prog_next = prog_reg + 2'd1;
            end
            else
            begin
                prog_next = (data_byte == CR) ? 2'd1 : 2'd0;
            end
            count_next = (count_reg == BODY_MAX) ? count_reg : count_reg + BODY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= 2'd0;
            count_reg <= '0;
        end
        else if (step)
        begin
            prog_reg  <= prog_next;
            count_reg <= count_next;
        end
    end

    // three delimiter bytes already counted
    always_comb
    begin
        info.frame_end = frame_end;
        if (count_reg == BODY_MAX)
        begin
            info.body_length = BODY_MAX;
        end
        else if (count_reg >= DELIM_PRE)
        begin
            info.body_length = count_reg - DELIM_PRE;
        end
        else
        begin
            info.body_length = '0;
        end
    end

endmodule

// File: design/dflc_field_parser.sv
// key search and decimal field parse within the body
module dflc_field_parser
    import dflc_pkg::*;
#(
    parameter int FIELD_WINDOW = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output field_info_t field
);

    localparam int WIN_W = $clog2(FIELD_WINDOW + 1);
    localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(FIELD_WINDOW);

    localparam logic [2:0] PH_SEEK  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_COLON = 3'd2;
    localparam logic [2:0] PH_SPACE = 3'd3;
    localparam logic [2:0] PH_DIGIT = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [2:0] KEY_LEN = 3'd7;
    localparam logic [7:0] KEY_PAT [7] = '{8'h6D, 8'h73, 8'h67, 8'h5F, 8'h6C, 8'h65, 8'h6E};
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int PROD_W = MAG_W + 4;

    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [2:0]       key_reg;
    logic [2:0]       key_next;
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic             neg_reg;
    logic             neg_next;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    logic             dig_reg;
    logic             dig_next;

    logic              is_space;
    logic              is_digit;
    logic              is_sign;
    logic              win_full;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  mag_digit;

    assign is_space = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
    assign win_full = (win_reg >= WIN_LIMIT);

    // times ten plus digit, saturating
    assign prod = PROD_W'({mag_reg, 3'b000}) + PROD_W'({mag_reg, 1'b0})
                + PROD_W'(data_byte[3:0]);
    assign mag_digit = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        win_next   = win_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        if (frame_end)
        begin
            phase_next = PH_SEEK;
            key_next   = 3'd0;
            win_next   = '0;
            neg_next   = 1'b0;
            mag_next   = '0;
            dig_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if ((key_reg != KEY_LEN) && (data_byte == KEY_PAT[key_reg]))
                    begin
                        key_next = key_reg + 3'd1;
                    end
                    else
                    begin
                        key_next = (data_byte == CH_M) ? 3'd1 : 3'd0;
                    end
                    if (key_next == KEY_LEN)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_COLON;
                end
                PH_COLON:
                begin
                    if (win_full)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        win_next = win_reg + WIN_W'(1);
                        if (data_byte == CH_COLON)
                        begin
                            phase_next = PH_COLON;
                        end
                        else if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (data_byte == CH_MINUS);
                            phase_next = PH_DIGIT;
                        end
                        else if (is_digit)
                        begin
                            mag_next   = mag_digit;
                            dig_next   = 1'b1;
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_SPACE:
                begin
                    if (win_full)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        win_next = win_reg + WIN_W'(1);
                        if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (data_byte == CH_MINUS);
                            phase_next = PH_DIGIT;
                        end
                        else if (is_digit)
                        begin
                            mag_next   = mag_digit;
                            dig_next   = 1'b1;
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_DIGIT:
                begin
                    if (win_full)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        win_next = win_reg + WIN_W'(1);
                        if (is_digit)
                        begin
                            mag_next = mag_digit;
                            dig_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            key_reg   <= 3'd0;
            win_reg   <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            dig_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            win_reg   <= win_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            dig_reg   <= dig_next;
        end
    end

    assign field.digits_seen = dig_reg;
    assign field.negative    = neg_reg;
    assign field.magnitude   = mag_reg;

endmodule

// File: design/delimited_frame_length_checker.sv
// Delimited frame length checker, top level. One beat carries one stream byte, echoed
// unchanged on the result side. A frame ends at the first CR LF CR LF; the beat of the
// last LF has frame_end set and carries the body length (bytes before the delimiter,
// saturating at 131071), the value declared after the first "msg_len" key in the body
// (one byte skipped, then up to FIELD_WINDOW bytes of colons, whitespace, sign and
// digits) and the status: ok, length mismatch, or field missing or unparsable. Throughput
// is one beat per clock while the output is not stalled; a beat passes an input register then
// the result register, with the delimiter, key and digit steps done combinationally between.
// Both sides may stall independently without loss.
module delimited_frame_length_checker
    import dflc_pkg::*;
#(
    parameter int FIELD_WINDOW = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               data_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               echo_byte,
    output logic                     frame_end,
    output logic [1:0]               frame_status,
    output logic [BODY_W-1:0]        body_length,
    output logic signed [DECL_W-1:0] declared_length
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    logic        advance;

    frame_info_t info;
    field_info_t field;

    logic [DECL_W-1:0] mag_ext;
    status_t           status;
    logic [DECL_W-1:0] declared;

    logic [7:0]        echo_reg;
    logic              end_reg;
    status_t           status_reg;
    logic [BODY_W-1:0] body_reg;
    logic [DECL_W-1:0] declared_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
        end
    end

    dflc_delim_track u_delim_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .info      (info)
    );

    dflc_field_parser #(
        .FIELD_WINDOW (FIELD_WINDOW)
    ) u_field_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .frame_end (info.frame_end),
        .field     (field)
    );

    assign mag_ext = DECL_W'(field.magnitude);

    always_comb
    begin
        status   = STATUS_OK;
        declared = '0;
        if (info.frame_end)
        begin
            if (field.digits_seen)
            begin
                declared = field.negative ? (DECL_W'(0) - mag_ext) : mag_ext;
                if (!field.negative && (field.magnitude == info.body_length))
                begin
                    status = STATUS_OK;
                end
                else
                begin
                    status = STATUS_MISMATCH;
                end
            end
            else
            begin
                status = STATUS_MISSING;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            echo_reg     <= s1_byte_reg;
            end_reg      <= info.frame_end;
            status_reg   <= status;
            body_reg     <= info.frame_end ? info.body_length : '0;
            declared_reg <= declared;
        end
    end

    assign out_valid       = out_valid_reg;
    assign echo_byte       = echo_reg;
    assign frame_end       = end_reg;
    assign frame_status    = status_reg;
    assign body_length     = body_reg;
    assign declared_length = declared_reg;

endmodule

// File: design/dflc_checker.sv
// port-level checks of the frame length checker and their bind
`include "delimited_frame_length_checker_assert.svh"

module dflc_checker
    import dflc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [7:0]               echo_byte,
    input logic                     frame_end,
    input logic [1:0]               frame_status,
    input logic [BODY_W-1:0]        body_length,
    input logic signed [DECL_W-1:0] declared_length
);

    // stalled result beat holds
    `DFLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(echo_byte) && $stable(frame_end), "result beat changed while stalled")

    // frame end only on the last line feed of the delimiter
    `DFLC_ASSERT_NOW(a_end_on_lf, out_valid && frame_end, echo_byte == 8'h0A, "frame end on a byte other than LF")

    // report fields quiet away from frame end
    `DFLC_ASSERT_NOW(a_quiet_mid, out_valid && !frame_end, frame_status == STATUS_OK && body_length == '0 && declared_length == '0, "report fields set off frame end")

    // no value reported when field missing
    `DFLC_ASSERT_NOW(a_missing_zero, out_valid && frame_end && frame_status == STATUS_MISSING, declared_length == '0, "value reported for a missing field")

    // status code in range
    `DFLC_ASSERT_NOW(a_status_code, out_valid && frame_end, frame_status == STATUS_OK || frame_status == STATUS_MISMATCH || frame_status == STATUS_MISSING, "undefined status code")

endmodule

bind delimited_frame_length_checker dflc_checker u_dflc_checker (.*);
